@@ rtl/utc_to_local_time_dst_top_assert.svh @@
// Assertion macros for the local time converter
`ifndef UTC_TO_LOCAL_TIME_DST_TOP_ASSERT_SVH
`define UTC_TO_LOCAL_TIME_DST_TOP_ASSERT_SVH

// same-cycle implication
`define ULDST_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ULDST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/uldst_pkg.sv @@
`timescale 1ns / 1ps
package uldst_pkg;

    localparam int DST_TABLE_YEARS = 13;
    localparam int DST_IDX_W       = $clog2(DST_TABLE_YEARS);
    localparam int DST_FIRST_YEAR  = 2013;

    localparam logic [3:0] DST_BEGIN_MONTH = 4'd3;
    localparam logic [3:0] DST_END_MONTH   = 4'd11;

    localparam logic [4:0] DST_BEGIN_DAY [DST_TABLE_YEARS] =
        '{5'd10, 5'd9, 5'd8, 5'd13, 5'd12, 5'd11, 5'd10,
          5'd8, 5'd14, 5'd13, 5'd12, 5'd10, 5'd9};
    localparam logic [4:0] DST_END_DAY [DST_TABLE_YEARS] =
        '{5'd3, 5'd2, 5'd1, 5'd6, 5'd5, 5'd4, 5'd3,
          5'd1, 5'd7, 5'd6, 5'd5, 5'd3, 5'd2};

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_ZONE_OFFSET = 3'd0;
    localparam logic [4:0] ZONE_OFFSET_RST = 5'h18;

    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [6:0] YEAR_SHORT_MAX = 7'd99;
    // 2^19 / 100, rounded up; exact for years below 4096
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic        time_valid;
        logic [11:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic [5:0]  utc_second;
    } t_utc_word;

    typedef struct packed {
        logic        result_valid;
        logic [4:0]  local_day;
        logic [3:0]  local_month;
        logic [6:0]  local_year_short;
        logic [4:0]  local_hour;
        logic [5:0]  local_minute;
        logic [5:0]  local_second;
    } t_local_word;

    function automatic logic [4:0] days_in(input logic [3:0] month);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/uldst_if.sv @@
`timescale 1ns / 1ps
interface uldst_in_if;
    logic                  valid;
    logic                  ready;
    uldst_pkg::t_utc_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uldst_out_if;
    logic                   valid;
    logic                   ready;
    uldst_pkg::t_local_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/uldst_cfg.sv @@
`timescale 1ns / 1ps
module uldst_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uldst_pkg::APB_AW-1:0]  paddr,
    input  logic [uldst_pkg::APB_DW-1:0]  pwdata,
    output logic [uldst_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output logic [4:0]                    o_zone_offset
);

    logic [4:0] r_zone_offset;
    logic [4:0] n_zone_offset;
    logic       wr_zone;

    assign pready  = 1'b1;
    assign wr_zone = psel && penable && pwrite && (paddr == uldst_pkg::REG_ZONE_OFFSET);

    always_comb begin
        n_zone_offset = r_zone_offset;
        if (wr_zone) begin
            n_zone_offset = pwdata[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_offset <= uldst_pkg::ZONE_OFFSET_RST;
        end else begin
            r_zone_offset <= n_zone_offset;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == uldst_pkg::REG_ZONE_OFFSET) begin
            prdata = {{(uldst_pkg::APB_DW-5){1'b0}}, r_zone_offset};
        end
    end

    assign o_zone_offset = r_zone_offset;

endmodule

@@ rtl/uldst_conv.sv @@
`timescale 1ns / 1ps
module uldst_conv (
    input  uldst_pkg::t_utc_word   i_word,
    input  logic [4:0]             i_zone_offset,
    output uldst_pkg::t_local_word o_word
);

    localparam logic [11:0] FIRST_YEAR = 12'(uldst_pkg::DST_FIRST_YEAR);
    localparam logic [11:0] TABLE_LEN  = 12'(uldst_pkg::DST_TABLE_YEARS);

    logic [11:0] year_off;
    logic        in_table;
    logic [uldst_pkg::DST_IDX_W-1:0] idx;
    logic [4:0]  begin_day;
    logic [4:0]  end_day;
    logic        after_begin;
    logic        before_end;
    logic        dst_on;
    logic [6:0]  hour_sum;
    logic        borrow;
    logic        carry;
    logic [6:0]  hour_fix;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [3:0]  prev_month;
    logic [4:0]  cur_len;
    logic        year_dec;
    logic        year_inc;
    logic [24:0] recip_prod;
    logic [5:0]  year_q;
    logic [11:0] year_q100;
    logic [6:0]  year_rem;
    logic [6:0]  year_short;

    assign month = i_word.utc_month;
    assign day   = i_word.utc_day;

    assign year_off  = i_word.utc_year - FIRST_YEAR;
    assign in_table  = (i_word.utc_year >= FIRST_YEAR) && (year_off < TABLE_LEN);
    assign idx       = year_off[uldst_pkg::DST_IDX_W-1:0];
    assign begin_day = in_table ? uldst_pkg::DST_BEGIN_DAY[idx] : 5'd0;
    assign end_day   = in_table ? uldst_pkg::DST_END_DAY[idx] : 5'd0;

    // day < 100, so month*100+day compares as (month, day)
    assign after_begin = (month > uldst_pkg::DST_BEGIN_MONTH) ||
                         ((month == uldst_pkg::DST_BEGIN_MONTH) && (day >= begin_day));
    assign before_end  = (month < uldst_pkg::DST_END_MONTH) ||
                         ((month == uldst_pkg::DST_END_MONTH) && (day < end_day));
    assign dst_on      = in_table && after_begin && before_end;

    assign hour_sum = {2'b00, i_word.utc_hour} + {{2{i_zone_offset[4]}}, i_zone_offset}
                    + {6'd0, dst_on};
    assign borrow   = hour_sum[6];
    assign carry    = !hour_sum[6] && (hour_sum[5:0] >= {1'b0, uldst_pkg::HOURS_PER_DAY});

    always_comb begin
        hour_fix = hour_sum;
        if (borrow) begin
            hour_fix = hour_sum + {2'b00, uldst_pkg::HOURS_PER_DAY};
        end else if (carry) begin
            hour_fix = hour_sum - {2'b00, uldst_pkg::HOURS_PER_DAY};
        end
    end

    assign prev_month = (month <= 4'd1) ? uldst_pkg::MONTHS_PER_YEAR : month - 4'd1;
    assign cur_len    = uldst_pkg::days_in(month);

    // year mod 100 by reciprocal multiply
    assign recip_prod = 25'(i_word.utc_year) * 25'(uldst_pkg::RECIP_100);
    assign year_q     = recip_prod[24:uldst_pkg::RECIP_SHIFT];
    assign year_q100  = {year_q, 6'd0} + {1'b0, year_q, 5'd0} + {4'd0, year_q, 2'd0};
    assign year_rem   = 7'(i_word.utc_year - year_q100);

    always_comb begin
        o_word                  = '0;
        year_dec                = 1'b0;
        year_inc                = 1'b0;
        year_short              = year_rem;
        o_word.result_valid     = 1'b1;
        o_word.local_day        = day;
        o_word.local_month      = month;
        o_word.local_hour       = hour_fix[4:0];
        o_word.local_minute     = i_word.utc_minute;
        o_word.local_second     = i_word.utc_second;
        if (borrow) begin
            if (day <= 5'd1) begin
                o_word.local_month = prev_month;
                o_word.local_day   = uldst_pkg::days_in(prev_month);
                year_dec           = (month <= 4'd1);
            end else begin
                o_word.local_day = day - 5'd1;
            end
        end else if (carry) begin
            if (day >= cur_len) begin
                o_word.local_day = 5'd1;
                if (month >= uldst_pkg::MONTHS_PER_YEAR) begin
                    o_word.local_month = 4'd1;
                    year_inc           = 1'b1;
                end else begin
                    o_word.local_month = month + 4'd1;
                end
            end else begin
                o_word.local_day = day + 5'd1;
            end
        end
        if (year_dec) begin
            year_short = (year_rem == 7'd0) ? uldst_pkg::YEAR_SHORT_MAX : year_rem - 7'd1;
        end else if (year_inc) begin
            year_short = (year_rem == uldst_pkg::YEAR_SHORT_MAX) ? 7'd0 : year_rem + 7'd1;
        end
        o_word.local_year_short = year_short;
        if (!i_word.time_valid) begin
            o_word = '0;
        end
    end

endmodule

@@ rtl/utc_to_local_time_dst_top.sv @@
// A word accepted on i_utc waits in the input register; its converted result
// is taken into the result register and offered on o_local. Throughput: one
// word per cycle while o_local.ready holds, each stage advancing when free.
// Reset (synchronous, active low) empties both stages and sets the zone
// offset to -8 hours.
`timescale 1ns / 1ps
module utc_to_local_time_dst_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    uldst_in_if.sink                      i_utc,
    uldst_out_if.source                   o_local,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uldst_pkg::APB_AW-1:0]  paddr,
    input  logic [uldst_pkg::APB_DW-1:0]  pwdata,
    output logic [uldst_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

`include "utc_to_local_time_dst_top_assert.svh"

    logic                   r_s1_v;
    logic                   n_s1_v;
    uldst_pkg::t_utc_word   r_s1_word;
    logic                   r_s2_v;
    logic                   n_s2_v;
    uldst_pkg::t_local_word r_s2_word;
    uldst_pkg::t_local_word conv_word;
    logic [4:0]             zone_offset;
    logic                   s1_ready;
    logic                   s2_ready;
    logic                   s1_load;
    logic                   s2_load;

    uldst_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_zone_offset (zone_offset)
    );

    uldst_conv u_conv (
        .i_word        (r_s1_word),
        .i_zone_offset (zone_offset),
        .o_word        (conv_word)
    );

    assign s2_ready    = !r_s2_v || o_local.ready;
    assign s1_ready    = !r_s1_v || s2_ready;
    assign i_utc.ready = s1_ready;
    assign s1_load     = i_utc.valid && s1_ready;
    assign s2_load     = r_s1_v && s2_ready;

    always_comb begin
        n_s1_v = r_s1_v;
        if (s1_ready) begin
            n_s1_v = i_utc.valid;
        end
        n_s2_v = r_s2_v;
        if (s2_ready) begin
            n_s2_v = r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
            r_s2_v <= n_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_word <= i_utc.data;
        end
        if (s2_load) begin
            r_s2_word <= conv_word;
        end
    end

    assign o_local.valid = r_s2_v;
    assign o_local.data  = r_s2_word;

    `ULDST_ASSERT_HOLDS(a_invalid_zero, i_clk, i_rst_n,
        r_s2_v && !r_s2_word.result_valid, r_s2_word == '0,
        "invalid word not all zero")
    `ULDST_ASSERT_HOLDS(a_hour_range, i_clk, i_rst_n,
        r_s2_v && r_s2_word.result_valid,
        r_s2_word.local_hour < uldst_pkg::HOURS_PER_DAY,
        "local hour out of range")
    `ULDST_ASSERT_HOLDS(a_year_range, i_clk, i_rst_n,
        r_s2_v && r_s2_word.result_valid,
        r_s2_word.local_year_short <= uldst_pkg::YEAR_SHORT_MAX,
        "short year out of range")
    `ULDST_ASSERT_NEXT(a_s1_fill, i_clk, i_rst_n,
        i_utc.valid && i_utc.ready, r_s1_v,
        "accepted word lost at input stage")
    `ULDST_ASSERT_NEXT(a_s2_fill, i_clk, i_rst_n,
        s2_load, r_s2_v,
        "word lost between stages")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    class local_time_scoreboard;
        uldst_pkg::t_local_word expected_q[$];
        logic signed [4:0]      zone_offset;
        int                     errors;
        int                     dst_start_md[uldst_pkg::DST_TABLE_YEARS];
        int                     dst_stop_md[uldst_pkg::DST_TABLE_YEARS];

        function new();
            zone_offset  = uldst_pkg::ZONE_OFFSET_RST;
            errors       = 0;
            dst_start_md = '{310, 309, 308, 313, 312, 311, 310, 308, 314, 313, 312, 310, 309};
            dst_stop_md  = '{1103, 1102, 1101, 1106, 1105, 1104, 1103, 1101, 1107, 1106,
                             1105, 1103, 1102};
        endfunction

        function int month_length(int month);
            if (month == 2) begin
                return 28;
            end else if (month == 4 || month == 6 || month == 9 || month == 11) begin
                return 30;
            end
            return 31;
        endfunction

        // local time for one accepted utc word
        function void note_input(uldst_pkg::t_utc_word w);
            uldst_pkg::t_local_word r;
            int yr, mo, dy, hr, idx, ys, md;
            r = '0;
            if (w.time_valid) begin
                yr  = int'(w.utc_year);
                mo  = int'(w.utc_month);
                dy  = int'(w.utc_day);
                hr  = int'(w.utc_hour) + zone_offset;
                idx = yr - uldst_pkg::DST_FIRST_YEAR;
                md  = mo * 100 + dy;
                if (idx >= 0 && idx < uldst_pkg::DST_TABLE_YEARS) begin
                    if (md >= dst_start_md[idx] && md < dst_stop_md[idx]) begin
                        hr++;
                    end
                end
                if (hr < 0) begin
                    hr += 24;
                    dy--;
                    if (dy < 1) begin
                        if (mo <= 1) begin
                            mo = 12;
                            yr--;
                        end else begin
                            mo--;
                        end
                        dy = month_length(mo);
                    end
                end else if (hr >= 24) begin
                    hr -= 24;
                    dy++;
                    if (dy > month_length(mo)) begin
                        dy = 1;
                        mo++;
                        if (mo > 12) begin
                            mo = 1;
                            yr++;
                        end
                    end
                end
                ys = (yr - 2000) % 100;
                if (ys < 0) begin
                    ys += 100;
                end
                r.result_valid     = 1'b1;
                r.local_day        = dy[4:0];
                r.local_month      = mo[3:0];
                r.local_year_short = ys[6:0];
                r.local_hour       = hr[4:0];
                r.local_minute     = w.utc_minute;
                r.local_second     = w.utc_second;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(uldst_pkg::t_local_word got);
            uldst_pkg::t_local_word exp_w;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected local word v%0d %0d-%0d-%0d %0d:%0d:%0d",
                             got.result_valid, got.local_year_short, got.local_month,
                             got.local_day, got.local_hour, got.local_minute, got.local_second);
                end
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.result_valid !== exp_w.result_valid || got.local_day !== exp_w.local_day ||
                got.local_month !== exp_w.local_month ||
                got.local_year_short !== exp_w.local_year_short ||
                got.local_hour !== exp_w.local_hour || got.local_minute !== exp_w.local_minute ||
                got.local_second !== exp_w.local_second) begin
                errors++;
                if (errors <= 10) begin
                    $display("local word mismatch: exp v%0d %0d-%0d-%0d %0d:%0d:%0d",
                             exp_w.result_valid, exp_w.local_year_short, exp_w.local_month,
                             exp_w.local_day, exp_w.local_hour, exp_w.local_minute,
                             exp_w.local_second);
                    $display("                      got v%0d %0d-%0d-%0d %0d:%0d:%0d",
                             got.result_valid, got.local_year_short, got.local_month,
                             got.local_day, got.local_hour, got.local_minute, got.local_second);
                end
            end
        endfunction
    endclass

    localparam int NUM_PHASES       = 8;
    localparam int WORDS_PER_PHASE  = 156;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [uldst_pkg::APB_AW-1:0] paddr;
    logic [uldst_pkg::APB_DW-1:0] pwdata;
    logic [uldst_pkg::APB_DW-1:0] prdata;
    logic                         pready;

    uldst_in_if  utc_if ();
    uldst_out_if local_if ();

    local_time_scoreboard sb;
    bit sink_idle_en;
    int hold_off_cycles;

    utc_to_local_time_dst_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_utc   (utc_if),
        .o_local (local_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #6000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic uldst_pkg::t_utc_word make_utc(bit v, int y, int m, int d, int h,
                                                      int mi, int s);
        uldst_pkg::t_utc_word w;
        w.time_valid = v;
        w.utc_year   = y[11:0];
        w.utc_month  = m[3:0];
        w.utc_day    = d[4:0];
        w.utc_hour   = h[4:0];
        w.utc_minute = mi[5:0];
        w.utc_second = s[5:0];
        return w;
    endfunction

    function automatic uldst_pkg::t_utc_word random_utc();
        uldst_pkg::t_utc_word w;
        int sel;
        w.time_valid = ($urandom_range(0, 19) != 0);
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            w.utc_year = 12'($urandom_range(0, 4095));
        end else if (sel == 1) begin
            w.utc_year = 12'($urandom_range(2000, 2099));
        end else begin
            w.utc_year = 12'($urandom_range(2011, 2027));
        end
        w.utc_month = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 12));
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            w.utc_day = 5'($urandom_range(0, 31));
        end else if (sel <= 2) begin
            w.utc_day = 5'd1;
        end else if (sel <= 4) begin
            w.utc_day = 5'($urandom_range(28, 31));
        end else if (sel == 5) begin
            // around the daylight-saving window edges
            w.utc_month = $urandom_range(0, 1) ? 4'd3 : 4'd11;
            w.utc_day   = 5'($urandom_range(1, 14));
        end else begin
            w.utc_day = 5'($urandom_range(1, 31));
        end
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            w.utc_hour = 5'($urandom_range(0, 31));
        end else if (sel == 1) begin
            w.utc_hour = $urandom_range(0, 1) ? 5'd23 : 5'd0;
        end else begin
            w.utc_hour = 5'($urandom_range(0, 23));
        end
        w.utc_minute = 6'($urandom_range(0, 63));
        w.utc_second = 6'($urandom_range(0, 63));
        return w;
    endfunction

    task automatic send_word(input uldst_pkg::t_utc_word w);
        @(negedge i_clk);
        utc_if.valid = 1'b1;
        utc_if.data  = w;
        do @(posedge i_clk); while (!utc_if.ready);
        sb.note_input(w);
    endtask

    // write the zone offset, then read it back
    task automatic program_zone_offset(input int hours);
        logic [uldst_pkg::APB_DW-1:0] word;
        word      = $urandom();
        word[4:0] = hours[4:0];
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = uldst_pkg::REG_ZONE_OFFSET;
        pwdata  = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.zone_offset = hours[4:0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[4:0] !== hours[4:0]) begin
            sb.errors++;
            if (sb.errors <= 10) begin
                $display("zone offset readback: exp %0d got %0d", hours[4:0], prdata[4:0]);
            end
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_directed();
        send_word(make_utc(0, 4095, 15, 31, 31, 63, 63));
        send_word(make_utc(1, 2013, 3, 10, 12, 0, 0));
        send_word(make_utc(1, 2013, 3, 9, 12, 1, 2));
        send_word(make_utc(1, 2013, 11, 3, 12, 3, 4));
        send_word(make_utc(1, 2013, 11, 2, 12, 5, 6));
        send_word(make_utc(1, 2025, 3, 9, 12, 7, 8));
        send_word(make_utc(1, 2025, 11, 1, 12, 9, 10));
        send_word(make_utc(1, 2012, 7, 1, 12, 11, 12));
        send_word(make_utc(1, 2026, 7, 1, 12, 13, 14));
        send_word(make_utc(1, 2020, 1, 1, 0, 15, 16));
        send_word(make_utc(1, 2021, 3, 1, 3, 17, 18));
        send_word(make_utc(1, 2000, 1, 1, 0, 19, 20));
        send_word(make_utc(1, 0, 1, 1, 0, 0, 0));
        send_word(make_utc(1, 4095, 12, 31, 31, 63, 63));
        send_word(make_utc(1, 2020, 6, 30, 31, 21, 22));
        send_word(make_utc(1, 2014, 0, 1, 2, 23, 24));
        send_word(make_utc(1, 2014, 13, 1, 0, 25, 26));
        send_word(make_utc(1, 2014, 15, 0, 31, 27, 28));
        send_word(make_utc(1, 2015, 14, 31, 0, 29, 30));
        send_word(make_utc(1, 2016, 5, 0, 1, 31, 32));
        send_word(make_utc(1, 2016, 6, 0, 31, 33, 34));
        send_word(make_utc(1, 2018, 3, 11, 7, 35, 36));
        send_word(make_utc(1, 2018, 2, 28, 31, 37, 38));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && local_if.valid && local_if.ready) begin
            sb.check_result(local_if.data);
        end
    end

    initial begin
        int idle_left;
        int cycles;
        bit quiet;
        idle_left      = 0;
        cycles         = 0;
        quiet          = 1'b0;
        local_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cycles++;
            if (cycles % 97 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                local_if.ready = 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                local_if.ready = 1'b0;
            end else if (sink_idle_en && !quiet && $urandom_range(0, 5) == 0) begin
                idle_left      = $urandom_range(1, 8) - 1;
                local_if.ready = 1'b0;
            end else begin
                local_if.ready = 1'b1;
            end
        end
    end

    initial begin
        int  zone_plan[NUM_PHASES];
        bit  src_quiet;
        bit  idling;
        zone_plan       = '{-8, -16, 15, -12, 14, 0, 5, -1};
        sb              = new();
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        utc_if.valid    = 1'b0;
        utc_if.data     = '0;
        sink_idle_en    = 1'b0;
        hold_off_cycles = 0;
        src_quiet       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idling = (phase != NUM_PHASES - 1);
            if (phase > 0) begin
                program_zone_offset(zone_plan[phase]);
            end
            sink_idle_en = idling;
            if (phase == 0) begin
                send_directed();
            end
            if (phase == 2) begin
                @(posedge i_clk);
                hold_off_cycles = 80;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    src_quiet = ($urandom_range(0, 2) == 0);
                end
                send_word(random_utc());
                if (idling && !src_quiet && $urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, 8)) begin
                        @(negedge i_clk);
                        utc_if.valid = 1'b0;
                        utc_if.data  = random_utc();
                    end
                end
            end
            @(negedge i_clk);
            utc_if.valid = 1'b0;
            while (sb.expected_q.size() != 0) begin
                @(posedge i_clk);
            end
            repeat (3) @(posedge i_clk);
        end

        repeat (6) @(posedge i_clk);
        sb.errors += sb.expected_q.size();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/uldst_pkg.sv
rtl/uldst_if.sv
rtl/uldst_cfg.sv
rtl/uldst_conv.sv
rtl/utc_to_local_time_dst_top.sv
sim/testbench.sv
